/* hdl/tsia_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsia_pkg
// Shared types and constants of the tensor store index access block.
// ----------------------------------------------------------------------------
package tsia_pkg;

  // Field widths of the stream words and the configuration registers
  localparam int COUNT_W  = 3;
  localparam int INDEX_W  = 12;
  localparam int SIZE_W   = 13;
  localparam int VALUE_W  = 64;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = SIZE_W;
  localparam int CFG_IDX_W = 3;

  // Dimensions carried by the request word, and how many the block honors
  localparam int FIELD_DIMS  = 4;
  localparam int MAX_DIMS    = 4;
  localparam int USABLE_DIMS = (MAX_DIMS < FIELD_DIMS) ? MAX_DIMS : FIELD_DIMS;
  localparam int DIM_W       = $clog2(FIELD_DIMS);

  // Defaults for the top level parameters
  localparam int DEPTH_DEF      = 4096;
  localparam int DATA_WIDTH_DEF = 64;

  // Stream word widths, padded to whole bytes
  localparam int IN_FIELDS_W  = COUNT_W + FIELD_DIMS * INDEX_W + VALUE_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = VALUE_W + STATUS_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_COUNT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_SIZE_3 = 3'd4;

  // Request commands
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0]                 dim_count;
    logic [FIELD_DIMS-1:0][SIZE_W-1:0]  dim_size;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_W-1:0]                 index_count;
    logic [FIELD_DIMS-1:0][INDEX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic                done;
    logic [STATUS_W-1:0] status;
  } addr_res_t;

  typedef enum logic [1:0] {
    A_IDLE,
    A_TERM,
    A_STRIDE,
    A_DONE
  } addr_state_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ADDR,
    S_READ,
    S_RESULT
  } state_t;

endpackage

/* hdl/tensor_store_index_access.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tensor_store_index_access
// Word store addressed by a multi-dimensional index, read or swap per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream: s_tuser is the command (read, or write
//   returning the old word), s_tdata the index count, four indices and the new
//   word. Each request yields one result word on the m_ stream: old word and
//   status (ok, index count mismatch, index out of range); errors return zero
//   and leave the store unchanged.
//   The cfg_ port sets the dimension count and sizes; write it only while idle.
//   A count mismatch skips the dimension walk, and any error skips the store
//   read. The next request is taken once the sequencer returns to idle, as
//   the result is registered. One request is handled at a time; the address
//   unit walks the dimensions through one shared multiplier (an index term
//   per dimension, a stride between them), plus the store's registered read.
//   After reset the store is cleared one word a cycle, all DEPTH words; no
//   request is taken until that pass ends. Configuration returns to one
//   dimension of size one.
//   A finished result sits in the output register; while the receiver stalls
//   a new request may be taken, and its result waits until that word leaves.
// ----------------------------------------------------------------------------
module tensor_store_index_access #(
  parameter int DEPTH      = tsia_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = tsia_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // index_count, index_0, index_1, index_2, index_3, new_value, zero pad
  input  logic [tsia_pkg::IN_DATA_W-1:0]    s_tdata,
  // cmd
  input  logic                              s_tuser,
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // old_value, status, zero pad
  output logic [tsia_pkg::OUT_DATA_W-1:0]   m_tdata,
  // Configuration write port
  input  logic                              cfg_wr_en,
  input  logic [tsia_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tsia_pkg::CFG_W-1:0]        cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int IDX_LO  = tsia_pkg::COUNT_W;
  localparam int VAL_LO  = tsia_pkg::COUNT_W + tsia_pkg::FIELD_DIMS * tsia_pkg::INDEX_W;

  tsia_pkg::state_t    state, state_next;
  tsia_pkg::cfg_t      cfg;
  tsia_pkg::req_t      req;
  tsia_pkg::addr_res_t addr_res;

  logic [AW-1:0]             flat_addr;
  logic [AW-1:0]             clr;
  logic [AW-1:0]             mem_addr;
  logic [DATA_WIDTH-1:0]     rd_data;
  logic [DATA_WIDTH-1:0]     mem [DEPTH];
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [DATA_WIDTH-1:0]     mem_wdata;

  logic                      cmd;
  logic [DATA_WIDTH-1:0]     new_value;
  logic                      ok;
  logic [tsia_pkg::STATUS_W-1:0] status;

  logic                          out_valid;
  logic [tsia_pkg::VALUE_W-1:0]  out_value;
  logic [tsia_pkg::STATUS_W-1:0] out_status;

  logic accept;
  logic out_free;
  logic finish;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign finish   = (state == tsia_pkg::S_RESULT) && out_free;
  assign s_tready = (state == tsia_pkg::S_IDLE);

  // Unpack the request word
  assign req.index_count = s_tdata[tsia_pkg::COUNT_W-1:0];
  assign req.index = s_tdata[VAL_LO-1:IDX_LO];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_count <= tsia_pkg::COUNT_W'(1);
      cfg.dim_size  <= {tsia_pkg::FIELD_DIMS{tsia_pkg::SIZE_W'(1)}};
    end else if (cfg_wr_en) begin
      if (cfg_index == tsia_pkg::CFG_DIM_COUNT) begin
        cfg.dim_count <= cfg_data[tsia_pkg::COUNT_W-1:0];
      end else if (cfg_index >= tsia_pkg::CFG_DIM_SIZE_0 &&
                   cfg_index <= tsia_pkg::CFG_DIM_SIZE_3) begin
        cfg.dim_size[tsia_pkg::DIM_W'(cfg_index - tsia_pkg::CFG_DIM_SIZE_0)] <=
          cfg_data[tsia_pkg::SIZE_W-1:0];
      end
    end
  end

  // Address unit
  tsia_addr #(
    .DEPTH (DEPTH)
  ) u_addr (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .req       (req),
    .cfg       (cfg),
    .res       (addr_res),
    .flat_addr (flat_addr)
  );

  // Main sequencer
  always_comb begin
    state_next = state;
    case (state)
      tsia_pkg::S_CLEAR: begin
        if (clr == AW'(DEPTH - 1)) begin
          state_next = tsia_pkg::S_IDLE;
        end
      end
      tsia_pkg::S_IDLE: begin
        if (accept) begin
          state_next = tsia_pkg::S_ADDR;
        end
      end
      tsia_pkg::S_ADDR: begin
        if (addr_res.done) begin
          state_next = (addr_res.status == tsia_pkg::ST_OK) ?
                       tsia_pkg::S_READ : tsia_pkg::S_RESULT;
        end
      end
      tsia_pkg::S_READ: begin
        state_next = tsia_pkg::S_RESULT;
      end
      tsia_pkg::S_RESULT: begin
        if (out_free) begin
          state_next = tsia_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tsia_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsia_pkg::S_CLEAR;
      clr   <= '0;
    end else begin
      state <= state_next;
      if (state == tsia_pkg::S_CLEAR) begin
        clr <= clr + 1'b1;
      end
    end
  end

  // Hold request payload and the address unit's answer
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd       <= s_tuser;
      new_value <= s_tdata[VAL_LO +: DATA_WIDTH];
    end
    if (state == tsia_pkg::S_ADDR && addr_res.done) begin
      status   <= addr_res.status;
      ok       <= (addr_res.status == tsia_pkg::ST_OK);
      mem_addr <= flat_addr;
    end
  end

  // Store write port: clearing pass, or write on finish
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mem_addr;
    mem_wdata = new_value;
    if (state == tsia_pkg::S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr;
      mem_wdata = '0;
    end else if (finish && ok && cmd == tsia_pkg::CMD_WRITE) begin
      mem_we = 1'b1;
    end
  end

  // Store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_addr];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_value  <= ok ? tsia_pkg::VALUE_W'(rd_data) : '0;
      out_status <= status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = tsia_pkg::OUT_DATA_W'({out_status, out_value});

endmodule

/* hdl/tsia_addr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsia_addr
// Iterative address unit: checks the index count, then walks the dimensions
// with one shared multiplier: an index term pass per dimension, a stride pass
// between dimensions. Flat address and stride saturate at DEPTH, enough to flag range.
// ----------------------------------------------------------------------------
module tsia_addr #(
  parameter int DEPTH = tsia_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  tsia_pkg::req_t            req,
  input  tsia_pkg::cfg_t            cfg,
  output tsia_pkg::addr_res_t       res,
  output logic [$clog2(DEPTH)-1:0]  flat_addr
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = tsia_pkg::SIZE_W + CW;

  tsia_pkg::addr_state_t state, state_next;

  logic [tsia_pkg::FIELD_DIMS-1:0][tsia_pkg::INDEX_W-1:0] index;
  logic [tsia_pkg::DIM_W-1:0] dim, dim_next;
  logic [CW-1:0]              stride, stride_next;
  logic [CW-1:0]              flat, flat_next;
  logic                       range_err, range_err_next;
  logic                       count_err, count_err_next;

  logic [tsia_pkg::INDEX_W-1:0] idx_sel;
  logic [tsia_pkg::SIZE_W-1:0]  size_sel;
  logic [tsia_pkg::SIZE_W-1:0]  mul_a;
  logic [PW-1:0]                prod;
  logic [PW:0]                  sum;
  logic                         count_bad;
  logic                         last_dim;

  // Select the current dimension
  assign idx_sel  = index[dim];
  assign size_sel = cfg.dim_size[dim];
  assign last_dim = (dim == tsia_pkg::DIM_W'(cfg.dim_count - 3'd1));

  // Shared multiplier: index times stride, or stride times size
  assign mul_a = (state == tsia_pkg::A_TERM) ? {1'b0, idx_sel} : size_sel;
  assign prod  = PW'(mul_a) * PW'(stride);
  assign sum   = {1'b0, PW'(flat)} + {1'b0, prod};

  // Count check on the incoming request
  assign count_bad = (cfg.dim_count == '0) ||
                     (cfg.dim_count > tsia_pkg::COUNT_W'(tsia_pkg::USABLE_DIMS)) ||
                     (req.index_count != cfg.dim_count);

  // Sequencer
  always_comb begin
    state_next     = state;
    dim_next       = dim;
    stride_next    = stride;
    flat_next      = flat;
    range_err_next = range_err;
    count_err_next = count_err;
    case (state)
      tsia_pkg::A_IDLE: begin
        if (start) begin
          dim_next       = '0;
          stride_next    = CW'(1);
          flat_next      = '0;
          range_err_next = 1'b0;
          count_err_next = count_bad;
          state_next     = count_bad ? tsia_pkg::A_DONE : tsia_pkg::A_TERM;
        end
      end
      tsia_pkg::A_TERM: begin
        if ({1'b0, idx_sel} >= size_sel) begin
          range_err_next = 1'b1;
        end
        flat_next  = (sum >= (PW + 1)'(DEPTH)) ? CW'(DEPTH) : CW'(sum);
        state_next = last_dim ? tsia_pkg::A_DONE : tsia_pkg::A_STRIDE;
      end
      tsia_pkg::A_STRIDE: begin
        stride_next = (prod >= PW'(DEPTH)) ? CW'(DEPTH) : CW'(prod);
        dim_next    = dim + 1'b1;
        state_next  = tsia_pkg::A_TERM;
      end
      tsia_pkg::A_DONE: begin
        state_next = tsia_pkg::A_IDLE;
      end
      default: begin
        state_next = tsia_pkg::A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsia_pkg::A_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    dim       <= dim_next;
    stride    <= stride_next;
    flat      <= flat_next;
    range_err <= range_err_next;
    count_err <= count_err_next;
    if (state == tsia_pkg::A_IDLE && start) begin
      index <= req.index;
    end
  end

  // Result
  always_comb begin
    res.done = (state == tsia_pkg::A_DONE);
    if (count_err) begin
      res.status = tsia_pkg::ST_COUNT;
    end else if (range_err || flat >= CW'(DEPTH)) begin
      res.status = tsia_pkg::ST_RANGE;
    end else begin
      res.status = tsia_pkg::ST_OK;
    end
  end

  assign flat_addr = flat[AW-1:0];

endmodule

/* test/tb_tensor_store_index_access.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tensor_store_index_access
// Self-checking bench for the multi-dimensional word store.
// ----------------------------------------------------------------------------
// A queue of request words is streamed into the block in random bursts. The
// bench keeps its own copy of the store and of the shape registers, predicts
// the old word and the status of every accepted request, and checks each
// result word in order. Phases change the shape between runs: default shape,
// exact fits of the store, sizes above the index range, a zero size, unusable
// dimension counts and writes to unused register slots. The result side
// stalls on shifting patterns and once for a long stretch.
// ----------------------------------------------------------------------------
module tb_tensor_store_index_access;
  import tsia_pkg::*;

  localparam int STORE_DEPTH = DEPTH_DEF;
  localparam int VALUE_OFS   = COUNT_W + FIELD_DIMS * INDEX_W;
  localparam int SETTLE      = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 20000;
  localparam int INDEX_SPAN  = 1 << INDEX_W;

  typedef struct {
    logic                 cmd;
    logic [IN_DATA_W-1:0] data;
  } request_t;

  typedef struct {
    logic [VALUE_W-1:0]  old_value;
    logic [STATUS_W-1:0] status;
  } access_result_t;

  typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = CMD_READ;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_DIM_COUNT;
  logic [CFG_W-1:0]      cfg_data = '0;

  // Bench copy of the shape registers and the store
  logic [COUNT_W-1:0] shape_dims = 3'd1;
  logic [SIZE_W-1:0]  shape_size [FIELD_DIMS];
  logic [VALUE_W-1:0] store_copy [STORE_DEPTH];

  request_t       request_queue [$];
  access_result_t awaited_results [$];
  access_result_t want;
  request_t       cur_request;

  logic [INDEX_W-1:0] last_index [FIELD_DIMS];
  bit                 have_last = 0;
  bit                 s_taken = 0;
  int                 gap_left = 0;
  int                 burst_left = 1;
  int                 hold_left = 0;
  int                 holds_asked = 0;
  int                 holds_done = 0;
  int                 rx_count = 0;
  rx_mode_t           rx_mode = RX_STEADY;
  int                 quiet_cycles = 0;
  int                 errors = 0;

  tensor_store_index_access dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Predict old word and status of one request, and apply a write to the copy
  function automatic access_result_t compute_access(logic cmd, logic [IN_DATA_W-1:0] data);
    logic [COUNT_W-1:0] count;
    logic [INDEX_W-1:0] idx;
    longint unsigned    stride;
    longint unsigned    flat;
    access_result_t     r;
    count       = data[COUNT_W-1:0];
    stride      = 1;
    flat        = 0;
    r.status    = ST_OK;
    r.old_value = '0;
    if (shape_dims < 1 || shape_dims > USABLE_DIMS || count != shape_dims) begin
      r.status = ST_COUNT;
    end else begin
      for (int d = 0; d < shape_dims; d++) begin
        idx = data[COUNT_W + d * INDEX_W +: INDEX_W];
        if (idx >= shape_size[d]) begin
          r.status = ST_RANGE;
        end else begin
          flat += idx * stride;
        end
        stride *= shape_size[d];
      end
      if (r.status == ST_OK && flat >= STORE_DEPTH) begin
        r.status = ST_RANGE;
      end
    end
    if (r.status == ST_OK) begin
      r.old_value = store_copy[flat];
      if (cmd == CMD_WRITE) begin
        store_copy[flat] = data[VALUE_OFS +: VALUE_W];
      end
    end
    return r;
  endfunction

  // Pack one request word and queue it
  function automatic void add_req(logic cmd, logic [COUNT_W-1:0] count,
                                  logic [INDEX_W-1:0] i0, logic [INDEX_W-1:0] i1,
                                  logic [INDEX_W-1:0] i2, logic [INDEX_W-1:0] i3,
                                  logic [VALUE_W-1:0] val);
    request_t r;
    r.cmd  = cmd;
    r.data = '0;
    r.data[COUNT_W-1:0]                   = count;
    r.data[COUNT_W +: INDEX_W]            = i0;
    r.data[COUNT_W + INDEX_W +: INDEX_W]  = i1;
    r.data[COUNT_W + 2*INDEX_W +: INDEX_W] = i2;
    r.data[COUNT_W + 3*INDEX_W +: INDEX_W] = i3;
    r.data[VALUE_OFS +: VALUE_W]          = val;
    request_queue.push_back(r);
  endfunction

  // Queue random requests: mostly valid indices for the current shape, some noise
  function automatic void add_random(int n);
    logic [INDEX_W-1:0] idx [FIELD_DIMS];
    logic [COUNT_W-1:0] count;
    logic [VALUE_W-1:0] val;
    int                 lim;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 2) begin
        count = COUNT_W'($urandom_range(0, 7));
        for (int d = 0; d < FIELD_DIMS; d++) begin
          idx[d] = INDEX_W'($urandom_range(0, INDEX_SPAN - 1));
        end
      end else begin
        if (shape_dims >= 1 && shape_dims <= USABLE_DIMS) count = shape_dims;
        else count = COUNT_W'($urandom_range(1, USABLE_DIMS));
        if (have_last && $urandom_range(0, 9) < 3) begin
          idx = last_index;
        end else begin
          for (int d = 0; d < FIELD_DIMS; d++) begin
            lim = (shape_size[d] > INDEX_SPAN) ? INDEX_SPAN : shape_size[d];
            if (d >= count || lim == 0) begin
              idx[d] = INDEX_W'($urandom_range(0, INDEX_SPAN - 1));
            end else if (lim < INDEX_SPAN && $urandom_range(0, 19) == 0) begin
              idx[d] = INDEX_W'(lim);
            end else begin
              idx[d] = INDEX_W'($urandom_range(0, lim - 1));
            end
          end
        end
        last_index = idx;
        have_last  = 1;
      end
      case ($urandom_range(0, 9))
        0:       val = '0;
        1:       val = '1;
        default: val = {$urandom, $urandom};
      endcase
      add_req($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, count,
              idx[0], idx[1], idx[2], idx[3], val);
    end
  endfunction

  // Write one register and mirror it; unused slots leave the shape alone
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_DIM_COUNT) shape_dims = val[COUNT_W-1:0];
    else if (idx <= CFG_DIM_SIZE_3) shape_size[idx - CFG_DIM_SIZE_0] = val;
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_shape(logic [CFG_W-1:0] dims, logic [CFG_W-1:0] s0,
                           logic [CFG_W-1:0] s1, logic [CFG_W-1:0] s2,
                           logic [CFG_W-1:0] s3);
    write_reg(CFG_DIM_COUNT, dims);
    write_reg(CFG_DIM_SIZE_0, s0);
    write_reg(CFG_DIM_SIZE_1, s1);
    write_reg(CFG_DIM_SIZE_2, s2);
    write_reg(CFG_DIM_SIZE_3, s3);
    cfg_done();
  endtask

  // Hold until every queued word is taken and every result has come back
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (request_queue.size() != 0 || s_tvalid || awaited_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Request driver: bursts with random gaps, valid held until taken
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (request_queue.size() != 0) begin
        cur_request = request_queue.pop_front();
        s_tdata  <= cur_request.data;
        s_tuser  <= cur_request.cmd;
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: stall pattern re-picked at random when its counter wraps, long hold on request
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (holds_asked != holds_done) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      if (rx_count == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_count = (rx_count + 1) % 64;
      case (rx_mode)
        RX_STEADY: m_tready <= 1'b1;
        RX_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:  m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= rx_count[0];
      endcase
    end
  end

  // Check result words in order, then predict newly accepted requests
  always @(posedge clk) begin
    if (rst) begin
      s_taken <= 1'b0;
    end else begin
      s_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result word: old_value %h status %0d",
                 m_tdata[VALUE_W-1:0], m_tdata[VALUE_W +: STATUS_W]);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (m_tdata[VALUE_W-1:0] !== want.old_value) begin
            $error("old_value: expected %h, actual %h", want.old_value, m_tdata[VALUE_W-1:0]);
            errors++;
          end
          if (m_tdata[VALUE_W +: STATUS_W] !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status,
                   m_tdata[VALUE_W +: STATUS_W]);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) awaited_results.push_back(compute_access(s_tuser, s_tdata));
    end
  end

  // Watchdog: end the run after a long stretch with no word moving
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    for (int a = 0; a < STORE_DEPTH; a++) store_copy[a] = '0;
    for (int d = 0; d < FIELD_DIMS; d++) shape_size[d] = 13'd1;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Default shape: one dimension of size one
    add_req(CMD_READ, 3'd1, 12'd0, 12'd0, 12'd0, 12'd0, '0);
    add_req(CMD_WRITE, 3'd1, 12'd0, 12'd7, 12'd9, 12'd4095, 64'hA5A5_5A5A_0F0F_F0F0);
    add_req(CMD_READ, 3'd1, 12'd0, 12'd0, 12'd0, 12'd0, '0);
    add_req(CMD_WRITE, 3'd1, 12'd1, 12'd0, 12'd0, 12'd0, '1);
    add_req(CMD_WRITE, 3'd2, 12'd0, 12'd0, 12'd0, 12'd0, '1);
    add_random(30);
    wait_idle();

    // 64 x 64 fills the store exactly: edges, size bounds, count mismatches
    set_shape(13'd2, 13'd64, 13'd64, 13'd1, 13'd1);
    add_req(CMD_WRITE, 3'd2, 12'd0, 12'd0, 12'd0, 12'd0, '1);
    add_req(CMD_READ, 3'd2, 12'd0, 12'd0, 12'd0, 12'd0, '0);
    add_req(CMD_WRITE, 3'd2, 12'd63, 12'd63, 12'd0, 12'd0, 64'h0123_4567_89AB_CDEF);
    add_req(CMD_WRITE, 3'd2, 12'd63, 12'd63, 12'd4095, 12'd4095, 64'h8000_0000_0000_0001);
    add_req(CMD_READ, 3'd2, 12'd63, 12'd63, 12'd0, 12'd0, '0);
    add_req(CMD_WRITE, 3'd2, 12'd64, 12'd0, 12'd0, 12'd0, '1);
    add_req(CMD_WRITE, 3'd2, 12'd5, 12'd64, 12'd0, 12'd0, '1);
    add_req(CMD_WRITE, 3'd2, 12'd4095, 12'd4095, 12'd0, 12'd0, '1);
    add_req(CMD_WRITE, 3'd1, 12'd5, 12'd5, 12'd0, 12'd0, '1);
    add_req(CMD_WRITE, 3'd0, 12'd5, 12'd5, 12'd0, 12'd0, '1);
    add_req(CMD_WRITE, 3'd3, 12'd5, 12'd5, 12'd0, 12'd0, '1);
    add_req(CMD_WRITE, 3'd7, 12'd5, 12'd5, 12'd0, 12'd0, '1);
    add_req(CMD_READ, 3'd2, 12'd5, 12'd5, 12'd0, 12'd0, '0);
    add_random(80);
    wait_idle();

    // One dimension spanning the whole store
    set_shape(13'd1, 13'd4096, 13'd1, 13'd1, 13'd1);
    add_random(80);
    wait_idle();

    // Four dimensions of eight; the result side holds off for a long stretch
    set_shape(13'd4, 13'd8, 13'd8, 13'd8, 13'd8);
    holds_asked++;
    add_random(100);
    wait_idle();

    // Flat address running past the store end
    set_shape(13'd2, 13'd4096, 13'd2, 13'd1, 13'd1);
    add_req(CMD_WRITE, 3'd2, 12'd4095, 12'd0, 12'd0, 12'd0, 64'hFEED_FACE_CAFE_F00D);
    add_req(CMD_READ, 3'd2, 12'd4095, 12'd0, 12'd0, 12'd0, '0);
    add_req(CMD_WRITE, 3'd2, 12'd0, 12'd1, 12'd0, 12'd0, '1);
    add_req(CMD_READ, 3'd2, 12'd4095, 12'd1, 12'd0, 12'd0, '0);
    add_random(60);
    wait_idle();

    // Sizes above the index range, mostly out of the store
    set_shape(13'd3, 13'd8191, 13'd8191, 13'd8191, 13'd8191);
    add_random(40);
    wait_idle();

    // A zero size rejects everything
    set_shape(13'd3, 13'd16, 13'd0, 13'd16, 13'd16);
    add_random(30);
    wait_idle();

    // Unusable dimension counts
    write_reg(CFG_DIM_COUNT, 13'd0);
    cfg_done();
    add_random(20);
    wait_idle();
    write_reg(CFG_DIM_COUNT, 13'd6);
    cfg_done();
    add_random(20);
    wait_idle();

    // Writes to unused register slots must not disturb the shape
    set_shape(13'd4, 13'd4, 13'd4, 13'd16, 13'd16);
    write_reg(CFG_DIM_SIZE_3 + 3'd1, 13'h1FFF);
    write_reg(CFG_DIM_SIZE_3 + 3'd2, 13'd0);
    write_reg(CFG_DIM_SIZE_3 + 3'd3, 13'h1FFF);
    cfg_done();
    add_random(100);
    wait_idle();

    // Single dimension larger than the index range
    set_shape(13'd1, 13'd8191, 13'd1, 13'd1, 13'd1);
    add_random(60);
    wait_idle();

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
